// File: hw/rtl/lhp_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the lidar hit packet parser
// no dependencies; every other file of the block but lhp_in_if uses this package

package lhp_pkg;

  localparam int unsigned HIT_COUNT_BITS_DEF = 16;

  // stream format
  localparam logic [7:0]  MAGIC_EVEN  = 8'h9C;
  localparam logic [7:0]  MAGIC_ODD   = 8'hAD;
  localparam int unsigned MAGIC_LEN   = 8;
  localparam int unsigned COUNT_LEN   = 4;
  localparam int unsigned TIME_LEN    = 8;
  localparam int unsigned PAD_LEN     = 4;
  localparam logic [15:0] MAX_RAW_POS = 16'd40000;
  localparam logic [15:0] POS_OFFSET  = 16'd20000;

  // configuration registers
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HITS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ID   = 1'd1;
  localparam logic [15:0] MAX_HITS_RESET = 16'd384;
  localparam logic [7:0]  MAX_ID_RESET   = 8'd31;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_HIT    = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_INCOMPLETE = 3'd1,
    ERR_BAD_MAGIC  = 3'd2,
    ERR_TOO_MANY   = 3'd3,
    ERR_POS_RANGE  = 3'd4,
    ERR_ID_RANGE   = 3'd5
  } err_t;

  typedef struct packed {
    logic [15:0] max_hits;
    logic [7:0]  max_id;
  } cfg_t;

  typedef struct packed {
    kind_t              kind;
    logic [63:0]        timestamp_us;
    logic [15:0]        hit_count;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [7:0]         hit_id;
    err_t               error_code;
    logic               last;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } res_req_t;

endpackage

// File: hw/rtl/lhp_in_if.sv
`timescale 1ns / 1ps
// byte stream channel into the parser
// depends on nothing

interface lhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

// File: hw/rtl/lhp_out_if.sv
`timescale 1ns / 1ps
// result channel out of the parser
// depends on lhp_pkg

interface lhp_out_if;
  logic               valid;
  logic               ready;
  lhp_pkg::kind_t     kind;
  logic [63:0]        timestamp_us;
  logic [15:0]        hit_count;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic [7:0]         hit_id;
  lhp_pkg::err_t      error_code;
  logic               last;

  modport source (
    output valid, output kind, output timestamp_us, output hit_count,
    output pos_x, output pos_y, output pos_z, output hit_id,
    output error_code, output last, input ready
  );
  modport sink (
    input valid, input kind, input timestamp_us, input hit_count,
    input pos_x, input pos_y, input pos_z, input hit_id,
    input error_code, input last, output ready
  );
endinterface

// File: hw/rtl/lhp_cfg_regs.sv
`timescale 1ns / 1ps
// configuration registers: max hit count and max hit id
// depends on lhp_pkg

module lhp_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lhp_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [lhp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output lhp_pkg::cfg_t                     cfg
);

  logic [15:0] max_hits_r;
  logic [7:0]  max_id_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_hits_r <= lhp_pkg::MAX_HITS_RESET;
      max_id_r   <= lhp_pkg::MAX_ID_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        lhp_pkg::CFG_MAX_HITS: max_hits_r <= cfg_wdata[15:0];
        lhp_pkg::CFG_MAX_ID:   max_id_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign cfg.max_hits = max_hits_r;
  assign cfg.max_id   = max_id_r;

endmodule

// File: hw/rtl/lhp_parser.sv
`timescale 1ns / 1ps
// packet parser state machine: magic search, field assembly, range checks
// depends on lhp_pkg; produces at most one result request per byte

module lhp_parser #(
  parameter int unsigned HIT_COUNT_BITS = lhp_pkg::HIT_COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              end_of_stream,
  input  lhp_pkg::cfg_t     cfg,
  output lhp_pkg::res_req_t res
);

  typedef enum logic [3:0] {
    PH_WAIT  = 4'd0,
    PH_HUNT  = 4'd1,
    PH_COUNT = 4'd2,
    PH_TIME  = 4'd3,
    PH_PAD   = 4'd4,
    PH_POS1  = 4'd5,
    PH_POS2  = 4'd6,
    PH_POS3  = 4'd7,
    PH_INTEN = 4'd8,
    PH_ID    = 4'd9
  } phase_t;

  localparam logic [2:0] MAGIC_LAST = 3'(lhp_pkg::MAGIC_LEN - 1);
  localparam logic [2:0] COUNT_LAST = 3'(lhp_pkg::COUNT_LEN - 1);
  localparam logic [2:0] TIME_LAST  = 3'(lhp_pkg::TIME_LEN - 1);
  localparam logic [2:0] PAD_LAST   = 3'(lhp_pkg::PAD_LEN - 1);
  localparam logic [2:0] POS_LAST   = 3'd1;
  localparam logic [2:0] BYTE_LAST  = 3'd0;

  phase_t                    phase_r, phase_nxt;
  logic [2:0]                idx_r, idx_nxt;
  logic [63:0]               field_r, field_nxt;
  logic [HIT_COUNT_BITS-1:0] hits_left_r, hits_left_nxt;
  logic [HIT_COUNT_BITS-1:0] hdr_count_r, hdr_count_nxt;
  logic [63:0]               hdr_time_r, hdr_time_nxt;
  logic [15:0]               pos1_r, pos1_nxt;
  logic [15:0]               pos2_r, pos2_nxt;
  logic [15:0]               pos3_r, pos3_nxt;

  logic [63:0]               acc;
  logic [2:0]                last_idx;
  logic [7:0]                want;
  logic [HIT_COUNT_BITS-1:0] hits_dec;

  // little-endian field assembly
  assign acc      = field_r | (64'(data_byte) << {idx_r, 3'b000});
  assign want     = idx_r[0] ? lhp_pkg::MAGIC_ODD : lhp_pkg::MAGIC_EVEN;
  assign hits_dec = hits_left_r - HIT_COUNT_BITS'(1);

  always_comb begin
    unique case (phase_r) inside
      PH_COUNT:                  last_idx = COUNT_LAST;
      PH_TIME:                   last_idx = TIME_LAST;
      PH_PAD:                    last_idx = PAD_LAST;
      PH_INTEN, PH_ID:           last_idx = BYTE_LAST;
      default:                   last_idx = POS_LAST;
    endcase
  end

  always_comb begin
    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    field_nxt     = field_r;
    hits_left_nxt = hits_left_r;
    hdr_count_nxt = hdr_count_r;
    hdr_time_nxt  = hdr_time_r;
    pos1_nxt      = pos1_r;
    pos2_nxt      = pos2_r;
    pos3_nxt      = pos3_r;
    res           = '0;

    if (step) begin
      if (end_of_stream) begin
        phase_nxt = PH_WAIT;
        idx_nxt   = '0;
        field_nxt = '0;
        if (!((phase_r == PH_WAIT && idx_r == '0) || phase_r == PH_HUNT)) begin
          res.valid           = 1'b1;
          res.data.kind       = lhp_pkg::KIND_ERROR;
          res.data.error_code = lhp_pkg::ERR_INCOMPLETE;
          res.data.last       = 1'b1;
        end
      end else begin
        unique case (phase_r) inside
          PH_WAIT, PH_HUNT: begin
            if (data_byte == want) begin
              if (idx_r == MAGIC_LAST) begin
                phase_nxt = PH_COUNT;
                idx_nxt   = '0;
              end else begin
                idx_nxt = idx_r + 3'd1;
              end
            end else begin
              if (phase_r == PH_WAIT) begin
                res.valid           = 1'b1;
                res.data.kind       = lhp_pkg::KIND_ERROR;
                res.data.error_code = lhp_pkg::ERR_BAD_MAGIC;
                res.data.last       = 1'b1;
              end
              phase_nxt = PH_HUNT;
              field_nxt = '0;
              // a stray first magic byte restarts the match
              idx_nxt   = (data_byte == lhp_pkg::MAGIC_EVEN) ? 3'd1 : 3'd0;
            end
          end
          PH_COUNT, PH_TIME, PH_PAD, PH_POS1, PH_POS2, PH_POS3, PH_INTEN, PH_ID: begin
            if (idx_r != last_idx) begin
              idx_nxt   = idx_r + 3'd1;
              field_nxt = acc;
            end else begin
              idx_nxt   = '0;
              field_nxt = '0;
              unique case (phase_r) inside
                PH_COUNT: begin
                  if (acc[31:0] > 32'(cfg.max_hits)) begin
                    res.valid           = 1'b1;
                    res.data.kind       = lhp_pkg::KIND_ERROR;
                    res.data.error_code = lhp_pkg::ERR_TOO_MANY;
                    res.data.last       = 1'b1;
                    phase_nxt           = PH_HUNT;
                  end else begin
                    hdr_count_nxt = acc[HIT_COUNT_BITS-1:0];
                    hits_left_nxt = acc[HIT_COUNT_BITS-1:0];
                    phase_nxt     = PH_TIME;
                  end
                end
                PH_TIME: begin
                  hdr_time_nxt = acc;
                  phase_nxt    = PH_PAD;
                end
                PH_PAD: begin
                  res.valid             = 1'b1;
                  res.data.kind         = lhp_pkg::KIND_HEADER;
                  res.data.timestamp_us = hdr_time_r;
                  res.data.hit_count    = 16'(hdr_count_r);
                  res.data.last         = (hits_left_r == '0);
                  phase_nxt             = (hits_left_r == '0) ? PH_WAIT : PH_POS1;
                end
                PH_POS1, PH_POS2, PH_POS3: begin
                  if (acc[15:0] > lhp_pkg::MAX_RAW_POS) begin
                    res.valid           = 1'b1;
                    res.data.kind       = lhp_pkg::KIND_ERROR;
                    res.data.error_code = lhp_pkg::ERR_POS_RANGE;
                    res.data.last       = 1'b1;
                    phase_nxt           = PH_HUNT;
                  end else if (phase_r == PH_POS1) begin
                    pos1_nxt  = acc[15:0];
                    phase_nxt = PH_POS2;
                  end else if (phase_r == PH_POS2) begin
                    pos2_nxt  = acc[15:0];
                    phase_nxt = PH_POS3;
                  end else begin
                    pos3_nxt  = acc[15:0];
                    phase_nxt = PH_INTEN;
                  end
                end
                PH_INTEN: phase_nxt = PH_ID;
                default: begin
                  if (acc[7:0] > cfg.max_id) begin
                    res.valid           = 1'b1;
                    res.data.kind       = lhp_pkg::KIND_ERROR;
                    res.data.error_code = lhp_pkg::ERR_ID_RANGE;
                    res.data.last       = 1'b1;
                    phase_nxt           = PH_HUNT;
                  end else begin
                    hits_left_nxt  = hits_dec;
                    res.valid      = 1'b1;
                    res.data.kind  = lhp_pkg::KIND_HIT;
                    // axes reordered to x forward, y left, z up
                    res.data.pos_x = lhp_pkg::POS_OFFSET - pos2_r;
                    res.data.pos_y = lhp_pkg::POS_OFFSET - pos1_r;
                    res.data.pos_z = lhp_pkg::POS_OFFSET - pos3_r;
                    res.data.hit_id = acc[7:0];
                    res.data.last   = (hits_dec == '0);
                    phase_nxt       = (hits_dec == '0) ? PH_WAIT : PH_POS1;
                  end
                end
              endcase
            end
          end
          default: begin
            phase_nxt = PH_WAIT;
            idx_nxt   = '0;
            field_nxt = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WAIT;
      idx_r       <= '0;
      field_r     <= '0;
      hits_left_r <= '0;
      hdr_count_r <= '0;
      hdr_time_r  <= '0;
      pos1_r      <= '0;
      pos2_r      <= '0;
      pos3_r      <= '0;
    end else begin
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      field_r     <= field_nxt;
      hits_left_r <= hits_left_nxt;
      hdr_count_r <= hdr_count_nxt;
      hdr_time_r  <= hdr_time_nxt;
      pos1_r      <= pos1_nxt;
      pos2_r      <= pos2_nxt;
      pos3_r      <= pos3_nxt;
    end
  end

endmodule

// File: hw/rtl/lhp_out_reg.sv
`timescale 1ns / 1ps
// result register between the parser and the result channel
// depends on lhp_pkg

module lhp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  lhp_pkg::res_req_t res,
  input  logic              out_ready,
  output logic              out_valid,
  output lhp_pkg::result_t  out_data,
  output logic              in_ready
);

  logic             valid_r;
  lhp_pkg::result_t data_r;

  // a new byte may enter when no result is held or the held result leaves in the same cycle
  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (step) begin
      valid_r <= res.valid;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      data_r <= res.data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// File: hw/rtl/lidar_hit_packet_parser.sv
`timescale 1ns / 1ps
// lidar hit packet parser, top level
// throughput: one stream byte per cycle while results are taken
// a result is in the output register in the cycle after the byte that causes it
// the input stalls only while a held result is not taken
// synchronous active-low reset: parser waits for a magic, limits return to 384 and 31

module lidar_hit_packet_parser #(
  parameter int unsigned HIT_COUNT_BITS = lhp_pkg::HIT_COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  lhp_in_if.sink                         in_ch,
  lhp_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [lhp_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [lhp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  lhp_pkg::cfg_t     cfg;
  lhp_pkg::res_req_t res;
  lhp_pkg::result_t  out_data;
  logic              in_ready;
  logic              step;

  assign step        = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  lhp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lhp_parser #(
    .HIT_COUNT_BITS (HIT_COUNT_BITS)
  ) u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .data_byte     (in_ch.data_byte),
    .end_of_stream (in_ch.end_of_stream),
    .cfg           (cfg),
    .res           (res)
  );

  lhp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .res       (res),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_data  (out_data),
    .in_ready  (in_ready)
  );

  assign out_ch.kind         = out_data.kind;
  assign out_ch.timestamp_us = out_data.timestamp_us;
  assign out_ch.hit_count    = out_data.hit_count;
  assign out_ch.pos_x        = out_data.pos_x;
  assign out_ch.pos_y        = out_data.pos_y;
  assign out_ch.pos_z        = out_data.pos_z;
  assign out_ch.hit_id       = out_data.hit_id;
  assign out_ch.error_code   = out_data.error_code;
  assign out_ch.last         = out_data.last;

  // error results always close the packet with a real code
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind == lhp_pkg::KIND_ERROR |->
      out_ch.last && out_ch.error_code != lhp_pkg::ERR_NONE)
    else $error("error result without last or code");

  a_code_only_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind != lhp_pkg::KIND_ERROR |->
      out_ch.error_code == lhp_pkg::ERR_NONE)
    else $error("error code on a non-error result");

  // an empty packet ends at its header
  a_hdr_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind == lhp_pkg::KIND_HEADER |->
      out_ch.last == (out_ch.hit_count == 16'd0))
    else $error("header last flag disagrees with hit count");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty result register");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// testbench of the lidar hit packet parser: byte stream in, header/hit/error results out
// depends on lhp_pkg, lhp_in_if, lhp_out_if and lidar_hit_packet_parser

typedef enum logic [3:0] {
  PH_WAIT, PH_HUNT, PH_COUNT, PH_TIME, PH_PAD,
  PH_POS1, PH_POS2, PH_POS3, PH_INTEN, PH_ID
} parse_phase_t;

class hit_packet_scoreboard;
  lhp_pkg::result_t due_results[$];
  int unsigned      mismatches;
  logic [15:0]      lim_hits;
  logic [7:0]       lim_id;
  parse_phase_t     ph;
  int unsigned      idx;
  logic [63:0]      acc;
  logic [15:0]      left;
  logic [15:0]      hdr_count;
  logic [63:0]      hdr_time;
  logic [15:0]      raw_a;
  logic [15:0]      raw_b;
  logic [15:0]      raw_c;

  function new();
    lim_hits   = lhp_pkg::MAX_HITS_RESET;
    lim_id     = lhp_pkg::MAX_ID_RESET;
    left       = '0;
    hdr_count  = '0;
    hdr_time   = '0;
    raw_a      = '0;
    raw_b      = '0;
    raw_c      = '0;
    mismatches = 0;
    enter(PH_WAIT);
  endfunction

  function void enter(parse_phase_t p);
    ph  = p;
    idx = 0;
    acc = '0;
  endfunction

  function void set_limit(logic [lhp_pkg::CFG_IDX_W-1:0] reg_idx,
                          logic [lhp_pkg::CFG_DATA_W-1:0] val);
    if (reg_idx == lhp_pkg::CFG_MAX_HITS) begin
      lim_hits = val;
    end else begin
      lim_id = val[7:0];
    end
  endfunction

  function void add_due(lhp_pkg::result_t r);
    due_results.insert(due_results.size(), r);
  endfunction

  function void push_error(lhp_pkg::err_t code, parse_phase_t nxt);
    lhp_pkg::result_t r;
    r            = '0;
    r.kind       = lhp_pkg::KIND_ERROR;
    r.error_code = code;
    r.last       = 1'b1;
    add_due(r);
    enter(nxt);
  endfunction

  // one accepted request of the byte stream
  function void take_byte(logic [7:0] b, logic eos);
    int unsigned      len;
    logic [7:0]       want;
    lhp_pkg::result_t r;
    if (eos) begin
      if ((ph == PH_WAIT && idx == 0) || ph == PH_HUNT) begin
        enter(PH_WAIT);
      end else begin
        push_error(lhp_pkg::ERR_INCOMPLETE, PH_WAIT);
      end
      return;
    end
    if (ph == PH_WAIT || ph == PH_HUNT) begin
      want = idx[0] ? lhp_pkg::MAGIC_ODD : lhp_pkg::MAGIC_EVEN;
      if (b == want) begin
        if (idx == lhp_pkg::MAGIC_LEN - 1) begin
          enter(PH_COUNT);
        end else begin
          idx++;
        end
      end else begin
        if (ph == PH_WAIT) begin
          push_error(lhp_pkg::ERR_BAD_MAGIC, PH_HUNT);
        end else begin
          enter(PH_HUNT);
        end
        // a stray first magic byte restarts the match
        idx = (b == lhp_pkg::MAGIC_EVEN) ? 1 : 0;
      end
      return;
    end
    case (ph)
      PH_COUNT:        len = lhp_pkg::COUNT_LEN;
      PH_TIME:         len = lhp_pkg::TIME_LEN;
      PH_PAD:          len = lhp_pkg::PAD_LEN;
      PH_INTEN, PH_ID: len = 1;
      default:         len = 2;
    endcase
    acc = acc | (64'(b) << (8 * idx));
    if (idx + 1 < len) begin
      idx++;
      return;
    end
    r = '0;
    case (ph)
      PH_COUNT: begin
        if (acc[31:0] > {16'd0, lim_hits}) begin
          push_error(lhp_pkg::ERR_TOO_MANY, PH_HUNT);
        end else begin
          hdr_count = acc[15:0];
          left      = acc[15:0];
          enter(PH_TIME);
        end
      end
      PH_TIME: begin
        hdr_time = acc;
        enter(PH_PAD);
      end
      PH_PAD: begin
        r.kind         = lhp_pkg::KIND_HEADER;
        r.timestamp_us = hdr_time;
        r.hit_count    = hdr_count;
        r.last         = (left == 16'd0);
        add_due(r);
        enter((left == 16'd0) ? PH_WAIT : PH_POS1);
      end
      PH_POS1, PH_POS2, PH_POS3: begin
        if (acc[15:0] > lhp_pkg::MAX_RAW_POS) begin
          push_error(lhp_pkg::ERR_POS_RANGE, PH_HUNT);
        end else if (ph == PH_POS1) begin
          raw_a = acc[15:0];
          enter(PH_POS2);
        end else if (ph == PH_POS2) begin
          raw_b = acc[15:0];
          enter(PH_POS3);
        end else begin
          raw_c = acc[15:0];
          enter(PH_INTEN);
        end
      end
      PH_INTEN: enter(PH_ID);
      default: begin
        if (acc[7:0] > lim_id) begin
          push_error(lhp_pkg::ERR_ID_RANGE, PH_HUNT);
        end else begin
          left = left - 16'd1;
          // axes reordered: forward from the second raw value, left from the first
          r.kind   = lhp_pkg::KIND_HIT;
          r.pos_x  = lhp_pkg::POS_OFFSET - raw_b;
          r.pos_y  = lhp_pkg::POS_OFFSET - raw_a;
          r.pos_z  = lhp_pkg::POS_OFFSET - raw_c;
          r.hit_id = acc[7:0];
          r.last   = (left == 16'd0);
          add_due(r);
          enter((left == 16'd0) ? PH_WAIT : PH_POS1);
        end
      end
    endcase
  endfunction

  function void match_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s expected %0h got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  function void check_result(lhp_pkg::result_t got);
    lhp_pkg::result_t want;
    if (due_results.size() == 0) begin
      $error("result with nothing due: kind %0d", got.kind);
      mismatches++;
      return;
    end
    want = due_results.pop_front();
    match_field("kind", 64'(want.kind), 64'(got.kind));
    match_field("timestamp_us", want.timestamp_us, got.timestamp_us);
    match_field("hit_count", 64'(want.hit_count), 64'(got.hit_count));
    match_field("pos_x", 64'(unsigned'(want.pos_x)), 64'(unsigned'(got.pos_x)));
    match_field("pos_y", 64'(unsigned'(want.pos_y)), 64'(unsigned'(got.pos_y)));
    match_field("pos_z", 64'(unsigned'(want.pos_z)), 64'(unsigned'(got.pos_z)));
    match_field("hit_id", 64'(want.hit_id), 64'(got.hit_id));
    match_field("error_code", 64'(want.error_code), 64'(got.error_code));
    match_field("last", 64'(want.last), 64'(got.last));
  endfunction

  function int unsigned pending();
    return due_results.size();
  endfunction
endclass

module tb_top;

  localparam int unsigned STALL_LIMIT = 1000;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [lhp_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [lhp_pkg::CFG_DATA_W-1:0] cfg_wdata;

  lhp_in_if  in_ch ();
  lhp_out_if out_ch ();

  lidar_hit_packet_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  hit_packet_scoreboard sb;
  logic [8:0]           pend[$];   // {end_of_stream, data_byte}
  int unsigned          items_done = 0;
  bit                   in_calm    = 1'b0;
  bit                   out_calm   = 1'b0;
  int unsigned          stuck      = 0;

  always #1 clk = ~clk;

  function automatic int unsigned draw_wait(input bit calm);
    if (calm) begin
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  // stretches with no idling on either side
  initial begin : calm_toggle
    forever begin
      repeat ($urandom_range(40, 400)) @(posedge clk);
      in_calm  <= ($urandom_range(0, 3) == 0);
      out_calm <= ($urandom_range(0, 3) == 0);
    end
  end

  task automatic put_item(input logic [7:0] b, input logic eos);
    int unsigned gap;
    gap = draw_wait(in_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= b;
    in_ch.end_of_stream <= eos;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    sb.take_byte(b, eos);
    items_done++;
  endtask

  task automatic send_pending();
    logic [8:0] it;
    while (pend.size() > 0) begin
      it = pend.pop_front();
      put_item(it[7:0], it[8]);
    end
  endtask

  task automatic add_pend(input logic [8:0] it);
    pend.insert(pend.size(), it);
  endtask

  task automatic push_le(input logic [63:0] v, input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      add_pend({1'b0, v[8*i +: 8]});
    end
  endtask

  task automatic push_header(input logic [31:0] cnt, input logic [63:0] ts);
    for (int unsigned i = 0; i < lhp_pkg::MAGIC_LEN; i++) begin
      push_le(i[0] ? lhp_pkg::MAGIC_ODD : lhp_pkg::MAGIC_EVEN, 1);
    end
    push_le(cnt, lhp_pkg::COUNT_LEN);
    push_le(ts, lhp_pkg::TIME_LEN);
    push_le($urandom, lhp_pkg::PAD_LEN);
  endtask

  task automatic push_hit(input logic [15:0] r1, input logic [15:0] r2,
                          input logic [15:0] r3, input logic [7:0] id);
    push_le(r1, 2);
    push_le(r2, 2);
    push_le(r3, 2);
    push_le($urandom, 1);
    push_le(id, 1);
  endtask

  function automatic logic [15:0] pick_raw();
    case ($urandom_range(0, 39))
      0:       return 16'd0;
      1:       return lhp_pkg::MAX_RAW_POS;
      2:       return 16'($urandom_range(lhp_pkg::MAX_RAW_POS + 1, 65535));
      default: return 16'($urandom_range(0, lhp_pkg::MAX_RAW_POS));
    endcase
  endfunction

  function automatic logic [7:0] pick_id();
    case ($urandom_range(0, 29))
      0:       return (sb.lim_id < 8'd255) ? 8'($urandom_range(sb.lim_id + 1, 255))
                                           : 8'($urandom);
      1:       return sb.lim_id;
      default: return 8'($urandom_range(0, sb.lim_id));
    endcase
  endfunction

  // holds the input idle, lets every due result come out, then waits on with the input still idle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [lhp_pkg::CFG_IDX_W-1:0] reg_idx,
                           input logic [lhp_pkg::CFG_DATA_W-1:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= reg_idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_limit(reg_idx, val);
  endtask

  task automatic rand_packet();
    int unsigned sel;
    int unsigned cap;
    int unsigned n_hits;
    int unsigned cut;
    int unsigned pos;
    logic [31:0] cnt;
    pend.delete();
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 5)) add_pend({1'b0, 8'($urandom)});
    end
    sel = $urandom_range(0, 15);
    if (sel == 0) begin
      // announced count above the limit
      cnt = $urandom_range(0, 1) ? $urandom : 32'(sb.lim_hits) + 32'd1;
      if (cnt <= {16'd0, sb.lim_hits}) begin
        cnt = 32'(sb.lim_hits) + 32'd1;
      end
      n_hits = 0;
    end else if (sel == 1) begin
      // packet cut short by the end of the stream
      cnt    = $urandom_range(0, sb.lim_hits);
      n_hits = (cnt < 3) ? cnt : 3;
    end else begin
      cap = (sb.lim_hits < 4) ? sb.lim_hits : 4;
      if (sel == 2 && sb.lim_hits >= 12) begin
        cap = 12;
      end
      cnt    = $urandom_range(0, cap);
      n_hits = cnt;
    end
    push_header(cnt, {$urandom, $urandom});
    repeat (n_hits) push_hit(pick_raw(), pick_raw(), pick_raw(), pick_id());
    if (sel == 1 || $urandom_range(0, 11) == 0) begin
      cut = $urandom_range(1, pend.size());
      while (pend.size() > cut) void'(pend.pop_back());
      add_pend({1'b1, 8'($urandom)});
    end else if ($urandom_range(0, 11) == 0) begin
      pos = $urandom_range(0, pend.size() - 1);
      pend[pos][7:0] = pend[pos][7:0] ^ 8'($urandom_range(1, 255));
    end
    if ($urandom_range(0, 9) == 0) begin
      add_pend({1'b1, 8'($urandom)});
    end
    send_pending();
  endtask

  // result side: random stalls, checks every accepted result
  initial begin : result_sink
    lhp_pkg::result_t got;
    int unsigned      stall;
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = draw_wait(out_calm);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (out_ch.valid !== 1'b1) @(posedge clk);
      got.kind         = out_ch.kind;
      got.timestamp_us = out_ch.timestamp_us;
      got.hit_count    = out_ch.hit_count;
      got.pos_x        = out_ch.pos_x;
      got.pos_y        = out_ch.pos_y;
      got.pos_z        = out_ch.pos_z;
      got.hit_id       = out_ch.hit_id;
      got.error_code   = out_ch.error_code;
      got.last         = out_ch.last;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1) begin
      stuck <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
      if (stuck >= STALL_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned p;
    int unsigned target;
    logic [15:0] lim_h;
    logic [7:0]  lim_i;
    sb = new();
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= '0;
    cfg_wdata           <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.data_byte     <= '0;
    in_ch.end_of_stream <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // stream end while idle gives nothing
    add_pend({1'b1, 8'h00});
    // magic broken on its fourth byte; the stray first byte restarts the match
    push_le({lhp_pkg::MAGIC_EVEN, lhp_pkg::MAGIC_EVEN, lhp_pkg::MAGIC_ODD,
             lhp_pkg::MAGIC_EVEN}, 4);
    for (int unsigned i = 1; i < lhp_pkg::MAGIC_LEN; i++) begin
      push_le(i[0] ? lhp_pkg::MAGIC_ODD : lhp_pkg::MAGIC_EVEN, 1);
    end
    push_le(32'd0, lhp_pkg::COUNT_LEN);
    push_le({64{1'b1}}, lhp_pkg::TIME_LEN);
    push_le($urandom, lhp_pkg::PAD_LEN);
    push_header(32'd2, 64'd0);
    push_hit(16'd0, lhp_pkg::MAX_RAW_POS, lhp_pkg::POS_OFFSET, 8'd0);
    push_hit(lhp_pkg::MAX_RAW_POS, 16'd0, 16'd12345, lhp_pkg::MAX_ID_RESET);
    push_header(32'(lhp_pkg::MAX_HITS_RESET) + 32'd1, {$urandom, $urandom});
    push_header(32'd1, {$urandom, $urandom});
    push_hit(16'd100, 16'd200, 16'hFFFF, 8'd0);
    push_header(32'd1, {$urandom, $urandom});
    push_hit(16'd1, 16'd2, 16'd3, lhp_pkg::MAX_ID_RESET + 8'd1);
    // packet cut off inside the magic
    push_le({lhp_pkg::MAGIC_EVEN, lhp_pkg::MAGIC_ODD, lhp_pkg::MAGIC_EVEN}, 3);
    add_pend({1'b1, 8'hFF});
    // stream end while hunting gives nothing
    add_pend({1'b0, 8'h00});
    add_pend({1'b1, 8'h00});
    send_pending();

    for (p = 0; p < 5; p++) begin
      case (p)
        0: begin
          lim_h = 16'd0;
          lim_i = 8'd0;
        end
        1: begin
          lim_h = 16'hFFFF;
          lim_i = 8'hFF;
        end
        2: begin
          lim_h = 16'($urandom_range(1, 8));
          lim_i = 8'($urandom);
        end
        default: begin
          lim_h = 16'($urandom);
          lim_i = 8'($urandom);
        end
      endcase
      write_cfg(lhp_pkg::CFG_MAX_HITS, lim_h);
      write_cfg(lhp_pkg::CFG_MAX_ID, {8'($urandom), lim_i});
      target = items_done + 240;
      while (items_done < target) rand_packet();
    end

    drain();
    if (sb.mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
